[rtl/core/ratg_pkg.sv]
package ratg_pkg;

	localparam int POSITION_BITS = 21;
	localparam int TIMER_BITS    = 32;
	localparam int ELAPSED_BITS  = 10;
	localparam int PULSE_BITS    = 8;
	localparam int ADC_BITS      = 12;
	localparam int KIND_BITS     = 3;
	localparam int FTP_BITS      = 20;
	localparam int SHORT_MS_BITS = 16;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_TICK      = 3'd0,
		KIND_OPEN_CLR  = 3'd1,
		KIND_CLOSE_CLR = 3'd2,
		KIND_STOP      = 3'd3,
		KIND_OPEN      = 3'd4,
		KIND_CLOSE     = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		MOT_IDLE    = 2'd0,
		MOT_OPENING = 2'd1,
		MOT_CLOSING = 2'd2,
		MOT_FAULT   = 2'd3
	} motion_t;

	typedef enum logic [2:0] {
		CAUSE_NONE    = 3'd0,
		CAUSE_OVER    = 3'd1,
		CAUSE_STALL   = 3'd2,
		CAUSE_TIMEOUT = 3'd3,
		CAUSE_UNDER   = 3'd4
	} cause_t;

	localparam logic [CFG_IDX_BITS-1:0] REG_FULL_TRAVEL = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_TRAVEL  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_STALL_TMO   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNDER_GRACE = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_OVER_LIMIT  = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNDER_LIMIT = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_ZERO_CODE   = 3'd6;

	typedef logic signed [POSITION_BITS-1:0] pos_t;

	typedef struct packed {
		logic [FTP_BITS-1:0]      full_travel_pulses;
		logic [TIMER_BITS-1:0]    max_travel_ms;
		logic [SHORT_MS_BITS-1:0] stall_gap_ms;
		logic [SHORT_MS_BITS-1:0] under_grace_ms;
		logic [ADC_BITS-1:0]      over_limit_counts;
		logic [ADC_BITS-1:0]      under_limit_counts;
		logic [ADC_BITS-1:0]      zero_code;
	} cfg_t;

	typedef struct packed {
		logic [KIND_BITS-1:0]    kind;
		logic [ELAPSED_BITS-1:0] elapsed_ms;
		logic [PULSE_BITS-1:0]   pulse_delta;
		logic                    open_limit_hit;
		logic                    close_limit_hit;
		logic [ADC_BITS-1:0]     current_sample;
	} item_t;

	typedef struct packed {
		motion_t                motion;
		cause_t                 cause;
		pos_t                   position;
		logic [TIMER_BITS-1:0]  move_ms;
		logic [TIMER_BITS-1:0]  since_pulse_ms;
	} state_t;

endpackage

[rtl/core/reversible_actuator_travel_guard.sv]
// a word accepted into the input register passes through the state update into the result register
// throughput: one word per cycle while the result side does not stall; the state update is a
//   single pass of compare/add logic between the input register and the result register
// stalls on the result side hold the result register and any word in the input register
// reset: motion idle, no fault, position and timers zero, registers at their defaults,
//   no word held in either stage
module reversible_actuator_travel_guard (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [ratg_pkg::KIND_BITS-1:0]           kind,
	input  logic [ratg_pkg::ELAPSED_BITS-1:0]        elapsed_ms,
	input  logic [ratg_pkg::PULSE_BITS-1:0]          pulse_delta,
	input  logic                                     open_limit_hit,
	input  logic                                     close_limit_hit,
	input  logic [ratg_pkg::ADC_BITS-1:0]            current_sample,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic                                     relay_open,
	output logic                                     relay_close,
	output logic [1:0]                               motion,
	output logic [2:0]                               fault_cause,
	output logic signed [ratg_pkg::POSITION_BITS-1:0] position,
	input  logic                                     cfg_we,
	input  logic [ratg_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [ratg_pkg::CFG_DATA_BITS-1:0]       cfg_data
);

	ratg_pkg::cfg_t   cfg;
	ratg_pkg::item_t  item_s1;
	logic             valid_s1;
	ratg_pkg::state_t state_q;
	ratg_pkg::state_t state_nxt;
	logic             out_valid_q;
	logic             relay_open_q;
	logic             relay_close_q;
	logic [1:0]       motion_q;
	logic [2:0]       cause_q;
	ratg_pkg::pos_t   position_q;
	logic             out_free;
	logic             step_en;

	ratg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ratg_step u_step (
		.cfg  (cfg),
		.st   (state_q),
		.item (item_s1),
		.nxt  (state_nxt)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !out_free;
	assign step_en  = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.kind            <= kind;
			item_s1.elapsed_ms      <= elapsed_ms;
			item_s1.pulse_delta     <= pulse_delta;
			item_s1.open_limit_hit  <= open_limit_hit;
			item_s1.close_limit_hit <= close_limit_hit;
			item_s1.current_sample  <= current_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.motion         <= ratg_pkg::MOT_IDLE;
			state_q.cause          <= ratg_pkg::CAUSE_NONE;
			state_q.position       <= '0;
			state_q.move_ms        <= '0;
			state_q.since_pulse_ms <= '0;
			out_valid_q            <= 1'b0;
		end else begin
			if (step_en) begin
				state_q <= state_nxt;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			relay_open_q  <= state_nxt.motion == ratg_pkg::MOT_OPENING;
			relay_close_q <= state_nxt.motion == ratg_pkg::MOT_CLOSING;
			motion_q      <= state_nxt.motion;
			cause_q       <= (state_nxt.motion == ratg_pkg::MOT_FAULT) ? state_nxt.cause
				: ratg_pkg::CAUSE_NONE;
			position_q    <= state_nxt.position;
		end
	end

	assign out_valid   = out_valid_q;
	assign relay_open  = relay_open_q;
	assign relay_close = relay_close_q;
	assign motion      = motion_q;
	assign fault_cause = cause_q;
	assign position    = position_q;

`ifndef NO_ASSERTIONS
	a_relays_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(relay_open && relay_close))
		else $error("both relays driven");

	a_cause_only_in_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && motion != ratg_pkg::MOT_FAULT) |-> (fault_cause == ratg_pkg::CAUSE_NONE))
		else $error("fault cause shown outside fault");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled while result side free");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(state_q))
		else $error("state changed without a word");

	a_result_follows_step: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> out_valid)
		else $error("processed word produced no result");
`endif

endmodule

[rtl/core/ratg_cfg.sv]
module ratg_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ratg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [ratg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output ratg_pkg::cfg_t                      cfg
);

	ratg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_travel_pulses <= '0;
			cfg_q.max_travel_ms      <= ratg_pkg::TIMER_BITS'(60000);
			cfg_q.stall_gap_ms       <= ratg_pkg::SHORT_MS_BITS'(2000);
			cfg_q.under_grace_ms     <= ratg_pkg::SHORT_MS_BITS'(1000);
			cfg_q.over_limit_counts  <= ratg_pkg::ADC_BITS'(1241);
			cfg_q.under_limit_counts <= '0;
			cfg_q.zero_code          <= ratg_pkg::ADC_BITS'(3102);
		end else if (cfg_we) begin
			case (cfg_index)
				ratg_pkg::REG_FULL_TRAVEL:
					cfg_q.full_travel_pulses <= cfg_data[ratg_pkg::FTP_BITS-1:0];
				ratg_pkg::REG_MAX_TRAVEL:
					cfg_q.max_travel_ms <= cfg_data[ratg_pkg::TIMER_BITS-1:0];
				ratg_pkg::REG_STALL_TMO:
					cfg_q.stall_gap_ms <= cfg_data[ratg_pkg::SHORT_MS_BITS-1:0];
				ratg_pkg::REG_UNDER_GRACE:
					cfg_q.under_grace_ms <= cfg_data[ratg_pkg::SHORT_MS_BITS-1:0];
				ratg_pkg::REG_OVER_LIMIT:
					cfg_q.over_limit_counts <= cfg_data[ratg_pkg::ADC_BITS-1:0];
				ratg_pkg::REG_UNDER_LIMIT:
					cfg_q.under_limit_counts <= cfg_data[ratg_pkg::ADC_BITS-1:0];
				ratg_pkg::REG_ZERO_CODE:
					cfg_q.zero_code <= cfg_data[ratg_pkg::ADC_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/ratg_step.sv]
module ratg_step (
	input  ratg_pkg::cfg_t   cfg,
	input  ratg_pkg::state_t st,
	input  ratg_pkg::item_t  item,
	output ratg_pkg::state_t nxt
);

	localparam int P = ratg_pkg::POSITION_BITS;
	localparam int T = ratg_pkg::TIMER_BITS;
	localparam int WIDE_BITS = 33;
	localparam logic [WIDE_BITS-1:0] POS_MAX_U = (WIDE_BITS'(1) << (P - 1)) - WIDE_BITS'(1);
	localparam ratg_pkg::pos_t POS_MAX = {1'b0, {(P-1){1'b1}}};
	localparam ratg_pkg::pos_t POS_MIN = {1'b1, {(P-1){1'b0}}};

	logic [T:0]                        me_sum;
	logic [T:0]                        sp_sum;
	logic [T-1:0]                      me_tick;
	logic [T-1:0]                      sp_tick;
	logic                              has_pulse;
	logic signed [P:0]                 pulse_ext;
	logic signed [P:0]                 pos_ext;
	logic signed [P:0]                 sum_up;
	logic signed [P:0]                 sum_dn;
	ratg_pkg::pos_t                    pos_up;
	ratg_pkg::pos_t                    pos_dn;
	logic [WIDE_BITS-1:0]              ft_wide;
	ratg_pkg::pos_t                    ft_pos;
	logic [ratg_pkg::ADC_BITS-1:0]     cur;
	logic                              moving;
	logic                              limit_stop;
	logic                              is_clear;
	logic                              open_dir;
	logic                              dir_limit;
	ratg_pkg::motion_t                 target;

	// saturating ms timers, 10-bit step into 32-bit count
	assign me_sum  = {1'b0, st.move_ms} + {{(T+1-ratg_pkg::ELAPSED_BITS){1'b0}}, item.elapsed_ms};
	assign sp_sum  = {1'b0, st.since_pulse_ms}
		+ {{(T+1-ratg_pkg::ELAPSED_BITS){1'b0}}, item.elapsed_ms};
	assign me_tick = me_sum[T] ? {T{1'b1}} : me_sum[T-1:0];
	assign has_pulse = item.pulse_delta != '0;
	assign sp_tick = has_pulse ? '0 : (sp_sum[T] ? {T{1'b1}} : sp_sum[T-1:0]);

	// position with overflow detected from the extra sign bit
	assign pulse_ext = $signed({{(P+1-ratg_pkg::PULSE_BITS){1'b0}}, item.pulse_delta});
	assign pos_ext   = {st.position[P-1], st.position};
	assign sum_up    = pos_ext + pulse_ext;
	assign sum_dn    = pos_ext - pulse_ext;
	assign pos_up    = (sum_up[P] != sum_up[P-1]) ? (sum_up[P] ? POS_MIN : POS_MAX)
		: sum_up[P-1:0];
	assign pos_dn    = (sum_dn[P] != sum_dn[P-1]) ? (sum_dn[P] ? POS_MIN : POS_MAX)
		: sum_dn[P-1:0];

	assign ft_wide = {{(WIDE_BITS-ratg_pkg::FTP_BITS){1'b0}}, cfg.full_travel_pulses};
	assign ft_pos  = (ft_wide > POS_MAX_U) ? POS_MAX : ft_wide[P-1:0];

	assign cur = (item.current_sample >= cfg.zero_code) ? item.current_sample - cfg.zero_code
		: cfg.zero_code - item.current_sample;

	assign moving     = (st.motion == ratg_pkg::MOT_OPENING) || (st.motion == ratg_pkg::MOT_CLOSING);
	assign limit_stop = ((st.motion == ratg_pkg::MOT_OPENING) && item.open_limit_hit)
		|| ((st.motion == ratg_pkg::MOT_CLOSING) && item.close_limit_hit);

	assign is_clear  = (item.kind == ratg_pkg::KIND_OPEN_CLR) || (item.kind == ratg_pkg::KIND_CLOSE_CLR);
	assign open_dir  = (item.kind == ratg_pkg::KIND_OPEN_CLR) || (item.kind == ratg_pkg::KIND_OPEN);
	assign dir_limit = open_dir ? item.open_limit_hit : item.close_limit_hit;
	assign target    = open_dir ? ratg_pkg::MOT_OPENING : ratg_pkg::MOT_CLOSING;

	always_comb begin
		nxt = st;
		case (item.kind)
			ratg_pkg::KIND_TICK: begin
				nxt.move_ms        = me_tick;
				nxt.since_pulse_ms = sp_tick;
				if (has_pulse && st.motion == ratg_pkg::MOT_OPENING) begin
					nxt.position = pos_up;
				end else if (has_pulse && st.motion == ratg_pkg::MOT_CLOSING) begin
					nxt.position = pos_dn;
				end
				if (item.open_limit_hit && cfg.full_travel_pulses != '0) begin
					nxt.position = ft_pos;
				end
				// close limit wins when both switches are active
				if (item.close_limit_hit) begin
					nxt.position = '0;
				end
				if (limit_stop) begin
					nxt.motion = ratg_pkg::MOT_IDLE;
				end else if (moving) begin
					if (cur > cfg.over_limit_counts) begin
						nxt.motion = ratg_pkg::MOT_FAULT;
						nxt.cause  = ratg_pkg::CAUSE_OVER;
					end else if (cfg.full_travel_pulses != '0
						&& sp_tick > {{(T-ratg_pkg::SHORT_MS_BITS){1'b0}}, cfg.stall_gap_ms}) begin
						nxt.motion = ratg_pkg::MOT_FAULT;
						nxt.cause  = ratg_pkg::CAUSE_STALL;
					end else if (me_tick > cfg.max_travel_ms) begin
						nxt.motion = ratg_pkg::MOT_FAULT;
						nxt.cause  = ratg_pkg::CAUSE_TIMEOUT;
					end else if (cfg.under_limit_counts != '0
						&& me_tick > {{(T-ratg_pkg::SHORT_MS_BITS){1'b0}}, cfg.under_grace_ms}
						&& cur < cfg.under_limit_counts) begin
						nxt.motion = ratg_pkg::MOT_FAULT;
						nxt.cause  = ratg_pkg::CAUSE_UNDER;
					end
				end
			end
			ratg_pkg::KIND_OPEN_CLR, ratg_pkg::KIND_CLOSE_CLR,
			ratg_pkg::KIND_OPEN, ratg_pkg::KIND_CLOSE: begin
				if (is_clear && st.motion == ratg_pkg::MOT_FAULT) begin
					nxt.motion = ratg_pkg::MOT_IDLE;
					nxt.cause  = ratg_pkg::CAUSE_NONE;
				end
				if (nxt.motion != ratg_pkg::MOT_FAULT) begin
					if (dir_limit) begin
						nxt.motion = ratg_pkg::MOT_IDLE;
					end else if (nxt.motion != target) begin
						nxt.motion         = target;
						nxt.move_ms        = '0;
						nxt.since_pulse_ms = '0;
					end
				end
			end
			ratg_pkg::KIND_STOP: begin
				if (st.motion != ratg_pkg::MOT_FAULT) begin
					nxt.motion = ratg_pkg::MOT_IDLE;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
